[hw/rtl/fadd_pkg.sv]
`timescale 1ns / 1ps
package fadd_pkg;
    localparam int ExtW = 28;

    typedef struct packed {
        logic        sgn;
        logic        sub;
        logic [7:0]  ebig;
        logic [27:0] big_m;
        logic [27:0] small_m;
    } align_t;

    typedef struct packed {
        logic        sgn;
        logic [7:0]  ebig;
        logic [27:0] raw;
        logic [4:0]  lz;
    } norm_t;
endpackage

[hw/rtl/fadd_align.sv]
`timescale 1ns / 1ps
module fadd_align (
    input  logic          [31:0] operand_a,
    input  logic          [31:0] operand_b,
    output fadd_pkg::align_t     result
);
    import fadd_pkg::*;

    logic [31:0] big;
    logic [31:0] small_op;
    logic [7:0]  esmall;
    logic [7:0]  diff;
    logic [26:0] sm27;
    logic [26:0] shifted;
    logic [26:0] lost_mask;

    always_comb
    begin
        if (operand_a[30:0] > operand_b[30:0])
        begin
            big      = operand_a;
            small_op = operand_b;
        end
        else
        begin
            big      = operand_b;
            small_op = operand_a;
        end
        esmall         = small_op[30:23];
        result.sgn     = big[31];
        result.sub     = operand_a[31] ^ operand_b[31];
        result.ebig    = big[30:23];
        result.big_m   = {1'b0, 1'b1, big[22:0], 3'b000};
        diff           = big[30:23] - esmall;
        sm27           = {1'b1, small_op[22:0], 3'b000};
        // shift of 27 or 28 keeps only the sticky bit
        shifted        = '0;
        lost_mask      = '1;
        if (diff < 8'd27)
        begin
            shifted   = sm27 >> diff[4:0];
            lost_mask = ~(27'h7ffffff << diff[4:0]);
        end
        if (esmall == 8'd0 || diff > 8'd28)
            result.small_m = '0;
        else if (diff == 8'd0)
            result.small_m = {1'b0, sm27};
        else
            result.small_m = {1'b0, shifted[26:1], shifted[0] | (|(sm27 & lost_mask))};
    end
endmodule

[hw/rtl/fadd_addlz.sv]
`timescale 1ns / 1ps
module fadd_addlz (
    input  fadd_pkg::align_t op,
    output fadd_pkg::norm_t  result
);
    import fadd_pkg::*;

    logic [27:0] raw;
    logic [4:0]  lz;

    always_comb
    begin
        raw = op.sub ? (op.big_m - op.small_m) : (op.big_m + op.small_m);
        lz  = 5'd28;
        for (int i = 0; i < ExtW; i++)
        begin
            if (raw[i])
                lz = 5'(ExtW - 1 - i);
        end
        result.sgn  = op.sgn;
        result.ebig = op.ebig;
        result.raw  = raw;
        result.lz   = lz;
    end
endmodule

[hw/rtl/fadd_round.sv]
`timescale 1ns / 1ps
module fadd_round (
    input  fadd_pkg::norm_t op,
    output logic [31:0]     sum_bits
);
    import fadd_pkg::*;

    logic [27:0] norm;
    logic [28:0] rnd;
    logic [4:0]  low5;
    logic [8:0]  e1;
    logic [7:0]  e;
    logic [22:0] mant;
    logic        zero;

    always_comb
    begin
        norm = op.raw << op.lz;
        low5 = norm[4:0];
        if (low5[4:3] == 2'b00 || low5 == 5'h08 || low5[4:3] == 2'b10)
            rnd = {1'b0, norm};
        else
            rnd = {1'b0, norm} + 29'h10;
        e1   = {1'b0, op.ebig} + 9'd1 - {4'd0, op.lz};
        zero = (op.lz > 5'd26) ||
               (op.ebig != 8'hff && ({1'b0, op.ebig} + 9'd1) < {4'd0, op.lz});
        e    = (op.ebig == 8'hff) ? 8'hff : e1[7:0];
        mant = rnd[26:4];
        if (rnd[28])
        begin
            mant = '0;
            if (e != 8'hff)
                e = e + 8'd1;
        end
        sum_bits = zero ? {op.sgn, 31'd0} : {op.sgn, e, mant};
    end
endmodule

[hw/rtl/float32_adder.sv]
`timescale 1ns / 1ps
// float32_adder: pipelined binary32 adder (non-IEEE exception handling).
// Input channel: in_valid/in_ready with operand_a, operand_b.
// Output channel: out_valid/out_ready with sum_bits.
// Three register stages: operand swap and alignment shift, add/subtract
// with leading-zero count, then normalize, round and pack.
// The result passes through s1_reg, s2_reg and s3_reg in order; out_valid
// is the valid bit of the last stage.
// Throughput is one item per cycle when the receiver takes every result.
// When out_ready is low a waiting result holds; a stage advances only when the
// stage after it is empty or advancing, so nothing is lost or repeated.
// Reset clears all stage valid bits; payload registers are not reset.
module float32_adder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] sum_bits
);
    import fadd_pkg::*;

    align_t      s1_next, s1_reg;
    norm_t       s2_next, s2_reg;
    logic [31:0] s3_next, s3_reg;
    logic        v1_reg, v2_reg, v3_reg;
    logic        adv1, adv2, adv3;

    fadd_align u_align (.operand_a(operand_a), .operand_b(operand_b), .result(s1_next));
    fadd_addlz u_addlz (.op(s1_reg), .result(s2_next));
    fadd_round u_round (.op(s2_reg), .sum_bits(s3_next));

    // backpressure chain
    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1) s1_reg <= s1_next;
        if (adv2) s2_reg <= s2_next;
        if (adv3) s3_reg <= s3_next;
    end

    assign out_valid = v3_reg;
    assign sum_bits  = s3_reg;
endmodule
